// File: rtl/bfd_pkg.sv
package bfd_pkg;

	// IEEE double layout.
	localparam int EXP_W  = 11;
	localparam int FRAC_W = 52;
	localparam int MANT_W = 53;

	localparam logic [EXP_W-1:0] EXP_BIAS = 11'd1023;
	localparam logic [EXP_W-1:0] EXP_MAX  = 11'd2047;

	// Constants of the formula as double bit patterns.
	localparam logic [63:0] ONE_BITS   = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] PHI_BITS   = 64'h3FF9_E377_9B97_F4A8;
	localparam logic [63:0] SQRT5_BITS = 64'h4001_E377_9B97_F4A8;
	localparam logic [63:0] INF_BITS   = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] ZERO_BITS  = 64'h0000_0000_0000_0000;

	// Full mantissa of sqrt5 with the hidden one.
	localparam logic [MANT_W-1:0] SQRT5_MANT = 53'h11_E377_9B97_F4A8;

endpackage

// File: rtl/bfd_fmul.sv
module bfd_fmul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] y
);
	import bfd_pkg::*;

	logic [52:0]  ma_q;
	logic [52:0]  mb_q;
	logic [11:0]  esum_q;
	logic         inf_q;
	logic [105:0] acc_q;
	logic [1:0]   step_q;
	logic         busy_q;
	logic         fin_q;
	logic         done_q;
	logic [63:0]  y_q;

	// Partial product of one 27 by 27 slice pair per cycle.
	logic [26:0]  pa;
	logic [26:0]  pb;
	logic [53:0]  pp;
	logic [105:0] pp_sh;

	always_comb begin
		pa = step_q[0] ? {1'b0, ma_q[52:27]} : ma_q[26:0];
		pb = step_q[1] ? {1'b0, mb_q[52:27]} : mb_q[26:0];
		pp = pa * pb;
		pp_sh = {52'd0, pp} << (7'd27 * ({6'd0, step_q[0]} + {6'd0, step_q[1]}));
	end

	// Normalize and round to nearest even.
	logic        norm;
	logic [52:0] mant_t;
	logic        g;
	logic        s;
	logic        inc;
	logic [53:0] mr;
	logic [12:0] e13;
	logic [63:0] y_c;

	always_comb begin
		norm = acc_q[105];
		mant_t = norm ? acc_q[105:53] : acc_q[104:52];
		g = norm ? acc_q[52] : acc_q[51];
		s = norm ? (|acc_q[51:0]) : (|acc_q[50:0]);
		inc = g & (s | mant_t[0]);
		mr = {1'b0, mant_t} + {53'd0, inc};
		e13 = {1'b0, esum_q} + {12'd0, norm} + {12'd0, mr[53]} - {2'b0, EXP_BIAS};
		if (inf_q || (e13 >= {2'b0, EXP_MAX})) begin
			y_c = INF_BITS;
		end else begin
			y_c = {1'b0, e13[EXP_W-1:0], (mr[53] ? 52'd0 : mr[51:0])};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
			if (fin_q) begin
				done_q <= 1'b1;
			end
		end
	end

	// Operand capture and accumulation.
	always_ff @(posedge clk) begin
		if (start) begin
			ma_q   <= {1'b1, a[51:0]};
			mb_q   <= {1'b1, b[51:0]};
			esum_q <= {1'b0, a[62:52]} + {1'b0, b[62:52]};
			inf_q  <= (a[62:52] == EXP_MAX) || (b[62:52] == EXP_MAX);
			acc_q  <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp_sh;
		end
		if (fin_q) begin
			y_q <= y_c;
		end
	end

	assign done = done_q;
	assign y    = y_q;

endmodule

// File: rtl/bfd_fdiv.sv
module bfd_fdiv (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] p,
	output logic        done,
	output logic [63:0] y
);
	import bfd_pkg::*;

	// Reciprocal of the sqrt5 mantissa scaled by 2^108. The truncated quotient
	// estimate it gives is at most one below the true quotient.
	localparam logic [111:0] RECIP_W = (112'd1 << 108) / {59'd0, SQRT5_MANT};
	localparam logic [55:0]  RECIP   = RECIP_W[55:0];

	// Sequencer steps: 0-3 estimate, 4-7 estimate times sqrt5, then remainder
	// and correction.
	localparam logic [3:0] STEP_EST  = 4'd3;
	localparam logic [3:0] STEP_REM  = 4'd8;
	localparam logic [3:0] STEP_LAST = 4'd9;

	logic [53:0]  r_q;
	logic [53:0]  q_q;
	logic [3:0]   step_q;
	logic [111:0] acc_q;
	logic [10:0]  exp_q;
	logic         inf_q;
	logic         busy_q;
	logic         fin_q;
	logic         done_q;
	logic [63:0]  y_q;

	// Prenormalize so that the quotient lands in [1, 2).
	logic [52:0] mp;
	logic        lt;

	always_comb begin
		mp = {1'b1, p[51:0]};
		lt = mp < SQRT5_MANT;
	end

	// One 28 by 28 slice pair per cycle, accumulated into a full product.
	logic [55:0]  op_x;
	logic [55:0]  op_y;
	logic [27:0]  pa;
	logic [27:0]  pb;
	logic [55:0]  pp;
	logic [111:0] pp_sh;
	logic [111:0] acc_nx;
	logic [54:0]  diff;

	always_comb begin
		op_x = step_q[2] ? {2'b0, q_q} : {2'b0, r_q};
		op_y = step_q[2] ? {3'b0, SQRT5_MANT} : RECIP;
		pa = step_q[0] ? op_x[55:28] : op_x[27:0];
		pb = step_q[1] ? op_y[55:28] : op_y[27:0];
		pp = pa * pb;
		pp_sh = {56'd0, pp} << (7'd28 * ({6'd0, step_q[0]} + {6'd0, step_q[1]}));
		acc_nx = acc_q + pp_sh;
		diff = {r_q[1:0], 53'd0} - acc_q[54:0];
	end

	// Correction step: the remainder is below twice sqrt5.
	logic        ge;
	logic [53:0] r_sub;

	always_comb begin
		ge = r_q >= {1'b0, SQRT5_MANT};
		r_sub = ge ? (r_q - {1'b0, SQRT5_MANT}) : r_q;
	end

	// Round the quotient to nearest even.
	logic        inc;
	logic [53:0] mr;
	logic [10:0] e_r;
	logic [63:0] y_c;

	always_comb begin
		inc = q_q[0] & ((|r_q) | q_q[1]);
		mr = {1'b0, q_q[53:1]} + {53'd0, inc};
		e_r = exp_q + {10'd0, mr[53]};
		if (inf_q) begin
			y_c = INF_BITS;
		end else begin
			y_c = {1'b0, e_r, (mr[53] ? 52'd0 : mr[51:0])};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= 4'd0;
		end else begin
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			if (start) begin
				step_q <= 4'd0;
				if (p[62:52] == EXP_MAX) begin
					fin_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				step_q <= step_q + 4'd1;
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
			if (fin_q) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= lt ? {mp, 1'b0} : {1'b0, mp};
			q_q   <= '0;
			acc_q <= '0;
			exp_q <= p[62:52] - 11'd1 - {10'd0, lt};
			inf_q <= (p[62:52] == EXP_MAX);
		end else if (busy_q) begin
			if (step_q == STEP_EST) begin
				q_q   <= acc_nx[108:55];
				acc_q <= '0;
			end else if (step_q < STEP_REM) begin
				acc_q <= acc_nx;
			end else if (step_q == STEP_REM) begin
				r_q <= diff[53:0];
			end else begin
				q_q <= q_q + {53'd0, ge};
				r_q <= r_sub;
			end
		end
		if (fin_q) begin
			y_q <= y_c;
		end
	end

	assign done = done_q;
	assign y    = y_q;

endmodule

// File: rtl/binet_fibonacci_double.sv
// Binet Fibonacci evaluator: value_bits = round(phi^index / sqrt5) as an IEEE
// double, every step rounded to nearest even, the last rounding half away.
// Input channel: in_valid, in_stall, index. A word is taken when in_valid is
// high and in_stall low; in_stall stays high while a word is being worked.
// Output channel: out_valid, out_stall, value_bits. The result word is held
// in an output register until it is taken, and a new input word may be taken
// while it waits. A finished result waits for that register to free up.
// Configuration: cfg_we and cfg_data write power_method; the user writes it
// only while idle, the block itself having no guard for it. One shared double
// multiplier (four 27x27 partial products per multiply) and a reciprocal
// divider (four 28x28 products for the estimate, four to check it) do the
// work. The count of multiplies m: square-and-multiply takes m = b + w, b the
// bit length of index (one for zero) and w its count of set bits; repeated
// multiplication takes m = index.
// Reset clears power_method to square-and-multiply and empties the output.
module binet_fibonacci_double #(
	parameter int INDEX_BITS = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [INDEX_BITS-1:0] index,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [63:0]           value_bits,
	input  logic                  cfg_we,
	input  logic                  cfg_data
);
	import bfd_pkg::*;

	localparam int PW = (INDEX_BITS > 1) ? $clog2(INDEX_BITS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_MWAIT,
		ST_DSTART,
		ST_DWAIT,
		ST_ROUND
	} state_t;

	state_t                state_q;
	logic                  method_q;
	logic [INDEX_BITS-1:0] n_q;
	logic [INDEX_BITS-1:0] cnt_q;
	logic [PW-1:0]         pos_q;
	logic                  op_sq_q;
	logic [63:0]           acc_q;
	logic [63:0]           quo_q;
	logic                  out_valid_q;
	logic [63:0]           out_q;

	logic        mul_start;
	logic        mul_done;
	logic [63:0] mul_y;
	logic        div_start;
	logic        div_done;
	logic [63:0] div_y;

	assign mul_start = (state_q == ST_ISSUE);
	assign div_start = (state_q == ST_DSTART);

	bfd_fmul u_fmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (acc_q),
		.b      (op_sq_q ? acc_q : PHI_BITS),
		.done   (mul_done),
		.y      (mul_y)
	);

	bfd_fdiv u_fdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.p      (acc_q),
		.done   (div_done),
		.y      (div_y)
	);

	// Position of the most significant set bit of the incoming index.
	logic [PW-1:0] top;

	always_comb begin
		top = '0;
		for (int i = 0; i < INDEX_BITS; i++) begin
			if (index[i]) begin
				top = PW'(i);
			end
		end
	end

	// Round half away from zero of the quotient.
	logic [10:0] qe;
	logic [52:0] qm;
	logic [10:0] e_int;
	logic [5:0]  sh;
	logic [52:0] int_part;
	logic [52:0] half_v;
	logic [53:0] whole;
	logic [53:0] ws;
	logic [63:0] rnd;

	always_comb begin
		qe = quo_q[62:52];
		qm = {1'b1, quo_q[51:0]};
		e_int = qe - EXP_BIAS;
		sh = 6'd52 - e_int[5:0];
		int_part = qm >> sh;
		half_v = qm >> (sh - 6'd1);
		whole = {1'b0, int_part} + {53'd0, half_v[0]};
		ws = whole << sh;
		if ((qe == EXP_MAX) || (qe >= (EXP_BIAS + 11'd52))) begin
			rnd = quo_q;
		end else if (qe < (EXP_BIAS - 11'd1)) begin
			rnd = ZERO_BITS;
		end else if (qe == (EXP_BIAS - 11'd1)) begin
			rnd = ONE_BITS;
		end else if (ws[53]) begin
			rnd = {1'b0, qe + 11'd1, 52'd0};
		end else begin
			rnd = {1'b0, qe, ws[51:0]};
		end
	end

	logic take_out;
	logic load_out;
	assign take_out = out_valid_q && !out_stall;
	assign load_out = (state_q == ST_ROUND) && (!out_valid_q || !out_stall);

	// Sequencer, configuration register and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			method_q    <= 1'b0;
			out_valid_q <= 1'b0;
			n_q         <= '0;
			cnt_q       <= '0;
			pos_q       <= '0;
			op_sq_q     <= 1'b0;
			acc_q       <= ONE_BITS;
			quo_q       <= ZERO_BITS;
			out_q       <= ZERO_BITS;
		end else begin
			if (cfg_we) begin
				method_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (take_out) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						n_q     <= index;
						cnt_q   <= index;
						pos_q   <= top;
						acc_q   <= ONE_BITS;
						op_sq_q <= !method_q;
						if (method_q && (index == '0)) begin
							state_q <= ST_DSTART;
						end else begin
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_ISSUE: begin
					state_q <= ST_MWAIT;
				end
				ST_MWAIT: begin
					if (mul_done) begin
						acc_q <= mul_y;
						if (method_q) begin
							cnt_q <= cnt_q - INDEX_BITS'(1);
							state_q <= (cnt_q == INDEX_BITS'(1)) ? ST_DSTART : ST_ISSUE;
						end else if (op_sq_q && n_q[pos_q]) begin
							op_sq_q <= 1'b0;
							state_q <= ST_ISSUE;
						end else if (pos_q == '0) begin
							state_q <= ST_DSTART;
						end else begin
							pos_q   <= pos_q - PW'(1);
							op_sq_q <= 1'b1;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_DSTART: begin
					state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (div_done) begin
						quo_q   <= div_y;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					if (load_out) begin
						out_q   <= rnd;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign value_bits = out_q;

endmodule

// File: tb/sv/bfd_checker.sv
module bfd_checker #(
	parameter int INDEX_BITS = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [INDEX_BITS-1:0] index,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [63:0]           value_bits,
	input  logic                  cfg_we,
	input  logic                  cfg_data,
	output int                    fail_count,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import bfd_pkg::*;

	logic        repeat_mode;
	logic [63:0] fib_words[$];

	// Binet value of n in double arithmetic, rounded half away from zero.
	function automatic logic [63:0] binet_bits(logic [INDEX_BITS-1:0] n, logic by_repeat);
		real    root5;
		real    golden;
		real    acc;
		real    quot;
		real    frac;
		longint whole;
		int     msb;
		root5  = $bitstoreal(SQRT5_BITS);
		golden = (root5 + 1.0) / 2.0;
		acc    = 1.0;
		msb    = 0;
		if (by_repeat) begin
			for (int k = 0; k < n; k++)
				acc = acc * golden;
		end else begin
			for (int b = 0; b < INDEX_BITS; b++)
				if (n[b]) msb = b;
			for (int b = msb; b >= 0; b--) begin
				acc = acc * acc;
				if (n[b]) acc = acc * golden;
			end
		end
		quot = acc / root5;
		// Values of 2^52 and above, infinity among them, are already integral.
		if (!(quot < 4503599627370496.0)) return $realtobits(quot);
		// Truncate without relying on how the cast rounds.
		whole = longint'(quot);
		if (real'(whole) > quot) whole = whole - 1;
		frac = quot - real'(whole);
		if (frac >= 0.5) whole = whole + 1;
		return $realtobits(real'(whole));
	endfunction

	// Track the register, predict on each input word, compare each output word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_mode = 1'b0;
			fib_words.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) repeat_mode = cfg_data;
			if (in_valid && !in_stall) fib_words.push_back(binet_bits(index, repeat_mode));
			if (out_valid && !out_stall) begin
				if (fib_words.size() == 0) begin
					$error("value_bits: no word expected, actual %h", value_bits);
					fail_count++;
				end else begin
					logic [63:0] want;
					want = fib_words.pop_front();
					if (value_bits !== want) begin
						$error("value_bits: expected %h, actual %h", want, value_bits);
						fail_count++;
					end
				end
			end
		end
		pending = fib_words.size();
	end
endmodule

// File: tb/sv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int INDEX_BITS  = 11;
	localparam int CYCLE_LIMIT = 20000000;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [INDEX_BITS-1:0] index;
	logic                  out_valid;
	logic                  out_stall;
	logic [63:0]           value_bits;
	logic                  cfg_we;
	logic                  cfg_data;
	int                    fail_count;
	int                    pending;
	int                    cycle_count;
	logic                  no_gaps;

	binet_fibonacci_double #(.INDEX_BITS(INDEX_BITS)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.index     (index),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value_bits(value_bits),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	bfd_checker #(.INDEX_BITS(INDEX_BITS)) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.index     (index),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value_bits(value_bits),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Guard against a hung handshake.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Receiver: random stall before each result word, none while no_gaps is set.
	initial begin
		int gap;
		out_stall = 1'b1;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = no_gaps ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Send one index word after a random gap; returns at a falling edge.
	task automatic send_index(input logic [INDEX_BITS-1:0] n);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		index    <= n;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Drain every outstanding word, let the block settle, then write the register.
	task automatic set_method(input logic by_repeat);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= by_repeat;
		@(negedge clk);
		cfg_we   <= 1'b0;
	endtask

	task automatic random_words(input int count, input logic by_repeat);
		logic [INDEX_BITS-1:0] n;
		for (int i = 0; i < count; i++) begin
			no_gaps = ((i / 40) % 3 == 2);
			if (!by_repeat || $urandom_range(0, 24) == 0) n = INDEX_BITS'($urandom);
			else n = INDEX_BITS'($urandom_range(0, 60));
			send_index(n);
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		in_valid = 1'b0;
		index    = '0;
		cfg_we   = 1'b0;
		cfg_data = 1'b0;
		no_gaps  = 1'b0;
		arst_n   = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Square-and-multiply out of reset: extremes, overflow boundary, single bits.
		send_index(11'd0);
		send_index(11'd1);
		send_index(11'd2);
		send_index(11'd3);
		send_index(11'd70);
		send_index(11'd78);
		send_index(11'd1474);
		send_index(11'd1475);
		send_index(11'd1476);
		send_index(11'd1024);
		send_index(11'd2047);
		send_index(11'd1365);
		send_index(11'd682);

		// Repeated multiplication, including the slowest index.
		set_method(1'b1);
		send_index(11'd0);
		send_index(11'd1);
		send_index(11'd2);
		send_index(11'd71);
		send_index(11'd80);
		send_index(11'd1476);
		send_index(11'd2047);

		// Back to square-and-multiply by an explicit write.
		set_method(1'b0);
		send_index(11'd5);
		random_words(200, 1'b0);
		set_method(1'b1);
		random_words(150, 1'b1);
		set_method(1'b0);
		random_words(150, 1'b0);

		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
